@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lkv_pkg.sv @@
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int RANK_W      = IDX_W;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic              OP_GET     = 1'b0;
  localparam logic              OP_PUT     = 1'b1;
  localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] PUT_VALUE  = {DATA_W{1'b0}};

endpackage

@@ rtl/core/lru_key_value_cache_top.sv @@
// a single key comparator walks the key memory in the scan state, the first scan step
// covering the read latency, then the update state and the result state follow
// the next request is taken the cycle after the result is registered, so the cache takes
// a new request only once the last one is through; a result still stalled at the output
// delays the result cycle
// synchronous active-low reset empties the cache and sets the capacity to 16; memories kept
module lru_key_value_cache_top
  import lkv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CAP_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic signed [DATA_W-1:0] in_lookup_key,
  input  logic signed [DATA_W-1:0] in_write_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value
);

  localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  state_t state_r;

  logic [CAP_W-1:0]       cap_r;
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [RANK_W-1:0]      rank_r [MAX_ENTRIES];
  logic [CNT_W-1:0]       used_r;
  logic [CNT_W-1:0]       cnt_r;

  logic              op_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] val_r;

  logic              found_r;
  logic [IDX_W-1:0]  found_idx_r;
  logic [RANK_W-1:0] found_rank_r;
  logic              vic_ok_r;
  logic [IDX_W-1:0]  vic_idx_r;
  logic [RANK_W-1:0] vic_rank_r;
  logic              free_ok_r;
  logic [IDX_W-1:0]  free_idx_r;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_value_r;

  logic              key_wr_en;
  logic              val_wr_en;
  logic              val_rd_en;
  logic              key_rd_en;
  logic [IDX_W-1:0]  tgt_idx;
  logic [RANK_W-1:0] tgt_limit;
  logic              age_all;
  logic              insert_new;
  logic              do_promote;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] val_q;

  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_hit;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  cap_eff;
  logic              full;
  logic              in_xfer;

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_read_value = out_value_r;

  // zero behaves as one, anything above the array size saturates
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full = CMP_W'(used_r) >= cap_eff;

  // key read for cnt_r is registered, so the compare runs one entry behind
  assign cmp_idx   = IDX_W'(cnt_r - CNT_W'(1));
  assign cmp_hit   = valid_r[cmp_idx] && (key_q == key_r);
  assign key_rd_en = (state_r == ST_SCAN) && (cnt_r < CNT_W'(MAX_ENTRIES));

  // target of the update cycle
  always_comb begin
    tgt_idx    = found_idx_r;
    tgt_limit  = found_rank_r;
    age_all    = 1'b0;
    insert_new = 1'b0;
    do_promote = 1'b0;
    key_wr_en  = 1'b0;
    val_wr_en  = 1'b0;
    val_rd_en  = 1'b0;
    if (state_r == ST_UPDATE) begin
      priority if (found_r) begin
        do_promote = 1'b1;
        val_wr_en  = (op_r == OP_PUT);
        val_rd_en  = (op_r == OP_GET);
      end else if (op_r == OP_PUT && full) begin
        tgt_idx    = vic_idx_r;
        tgt_limit  = vic_rank_r;
        do_promote = vic_ok_r;
        key_wr_en  = vic_ok_r;
        val_wr_en  = vic_ok_r;
      end else if (op_r == OP_PUT) begin
        tgt_idx    = free_idx_r;
        age_all    = 1'b1;
        insert_new = free_ok_r;
        do_promote = free_ok_r;
        key_wr_en  = free_ok_r;
        val_wr_en  = free_ok_r;
      end else begin
        // get miss leaves the store as it is
        do_promote = 1'b0;
      end
    end
  end

  lkv_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (DATA_W)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (tgt_idx),
    .wr_data (key_r),
    .rd_en   (key_rd_en),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (key_q)
  );

  lkv_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (DATA_W)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (tgt_idx),
    .wr_data (val_r),
    .rd_en   (val_rd_en),
    .rd_addr (tgt_idx),
    .rd_data (val_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      // the result cycle reloads the output register itself
      if (out_valid_r && !out_stall && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            op_r      <= in_op;
            key_r     <= in_lookup_key;
            val_r     <= in_write_value;
            cnt_r     <= '0;
            found_r   <= 1'b0;
            vic_ok_r  <= 1'b0;
            free_ok_r <= 1'b0;
            state_r   <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r != '0) begin
            if (cmp_hit && !found_r) begin
              found_r      <= 1'b1;
              found_idx_r  <= cmp_idx;
              found_rank_r <= rank_r[cmp_idx];
            end
            if (valid_r[cmp_idx] && (!vic_ok_r || rank_r[cmp_idx] > vic_rank_r)) begin
              vic_ok_r   <= 1'b1;
              vic_idx_r  <= cmp_idx;
              vic_rank_r <= rank_r[cmp_idx];
            end
            if (!valid_r[cmp_idx] && !free_ok_r) begin
              free_ok_r  <= 1'b1;
              free_idx_r <= cmp_idx;
            end
          end
          if (cnt_r == CNT_W'(MAX_ENTRIES)) begin
            state_r <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          if (do_promote) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (IDX_W'(i) == tgt_idx) begin
                rank_r[i] <= '0;
              end else if (valid_r[i] && (age_all || rank_r[i] < tgt_limit)) begin
                rank_r[i] <= rank_r[i] + RANK_W'(1);
              end
            end
          end
          if (insert_new) begin
            valid_r[tgt_idx] <= 1'b1;
            used_r           <= used_r + CNT_W'(1);
          end
          state_r <= ST_RESP;
        end

        ST_RESP: begin
          // hold the result back until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= found_r;
            if (op_r == OP_PUT) begin
              out_value_r <= PUT_VALUE;
            end else if (found_r) begin
              out_value_r <= val_q;
            end else begin
              out_value_r <= MISS_VALUE;
            end
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/lkv_ram.sv @@
module lkv_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/lkv_checker.sv @@
`include "assert_macros.svh"

module lkv_checker
  import lkv_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_hit,
  input logic signed [DATA_W-1:0] out_read_value
);

  // one request at a time: busy straight after a transfer in
  `ASSERT_CLK(a_busy_after_take, in_valid && !in_stall |=> in_stall, "input taken while busy")

  // a lookup goes through the scan, update and result states, so no fresh result the cycle after a transfer in
  `ASSERT_CLK(a_no_instant_result, in_valid && !in_stall |=> !$rose(out_valid), "result too early")

  // a miss gives either the get miss marker or the put zero
  `ASSERT_CLK(a_miss_value, out_valid && !out_hit |-> out_read_value == MISS_VALUE || out_read_value == PUT_VALUE, "bad miss value")

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_read_value) && $stable(out_hit), "stalled result changed")

  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result after reset")

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_read_value (out_read_value)
);

@@ verif/lru_key_value_cache_top_test.sv @@
typedef struct packed {
  logic                        hit;
  logic [lkv_pkg::DATA_W-1:0]  value;
} cache_reply_t;

class lru_scoreboard;
  logic [lkv_pkg::DATA_W-1:0] slot_key   [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::DATA_W-1:0] slot_value [lkv_pkg::MAX_ENTRIES];
  bit                         slot_valid [lkv_pkg::MAX_ENTRIES];
  int unsigned                slot_rank  [lkv_pkg::MAX_ENTRIES];
  int unsigned                used_count;
  int unsigned                capacity;
  cache_reply_t               replies_due[$];
  int                         mismatches;
  int                         requests;
  int                         hits;
  int                         evictions;

  function new();
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_valid[i] = 1'b0;
      slot_rank[i]  = 0;
    end
    used_count = 0;
    capacity   = lkv_pkg::CAP_RESET;
    mismatches = 0;
    requests   = 0;
    hits       = 0;
    evictions  = 0;
  endfunction

  function void write_capacity(logic [lkv_pkg::CAP_W-1:0] value);
    capacity = value;
  endfunction

  // zero behaves as one, anything above the entry count saturates
  function int unsigned capped_capacity();
    if (capacity == 0) return 1;
    if (capacity > lkv_pkg::MAX_ENTRIES) return lkv_pkg::MAX_ENTRIES;
    return capacity;
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  // slot s becomes most recent, entries more recent than limit age by one
  function void make_recent(int s, int unsigned limit);
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
      if (i != s && slot_valid[i] && slot_rank[i] < limit) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  function void note_request(logic op, logic [lkv_pkg::DATA_W-1:0] key,
                             logic [lkv_pkg::DATA_W-1:0] value);
    int           found;
    int           target;
    cache_reply_t reply;
    found = -1;
    target = -1;
    requests++;
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    end
    if (found >= 0) begin
      hits++;
      reply.hit = 1'b1;
      make_recent(found, slot_rank[found]);
      if (op == lkv_pkg::OP_GET) begin
        reply.value = slot_value[found];
      end else begin
        slot_value[found] = value;
        reply.value = lkv_pkg::PUT_VALUE;
      end
    end else if (op == lkv_pkg::OP_GET) begin
      reply.hit   = 1'b0;
      reply.value = lkv_pkg::MISS_VALUE;
    end else begin
      reply.hit   = 1'b0;
      reply.value = lkv_pkg::PUT_VALUE;
      if (used_count >= capped_capacity()) begin
        // replace the least recent entry, first one wins on a tie
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
          if (slot_valid[i] && (target < 0 || slot_rank[i] > slot_rank[target])) target = i;
        end
        if (target >= 0) begin
          evictions++;
          slot_key[target]   = key;
          slot_value[target] = value;
          make_recent(target, slot_rank[target]);
        end
      end else begin
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
          if (target < 0 && !slot_valid[i]) target = i;
        end
        if (target >= 0) begin
          slot_key[target]   = key;
          slot_value[target] = value;
          slot_valid[target] = 1'b1;
          make_recent(target, lkv_pkg::MAX_ENTRIES + 1);
          used_count++;
        end
      end
    end
    replies_due.push_back(reply);
  endfunction

  function void report(string what, logic [lkv_pkg::DATA_W-1:0] want,
                       logic [lkv_pkg::DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  function void check_result(logic hit, logic [lkv_pkg::DATA_W-1:0] value);
    cache_reply_t want;
    if (replies_due.size() == 0) begin
      report("unexpected result (value)", '0, value);
      return;
    end
    want = replies_due.pop_front();
    if (want.hit !== hit) report("hit", want.hit, hit);
    if (want.value !== value) report("read value", want.value, value);
  endfunction
endclass

module lru_key_value_cache_top_test;
  import lkv_pkg::*;

  localparam int PHASE_ITEMS = 153;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CAP_W-1:0]         cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_op;
  logic signed [DATA_W-1:0] in_lookup_key;
  logic signed [DATA_W-1:0] in_write_value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_hit;
  logic signed [DATA_W-1:0] out_read_value;

  lru_scoreboard board = new();
  bit            tx_gaps_on;
  bit            rx_gaps_on;
  int            capacity_writes;

  lru_key_value_cache_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_request(in_op, in_lookup_key, in_write_value);
    if (rst_n && out_valid && !out_stall) board.check_result(out_hit, out_read_value);
  end

  // result side: a random hold before each transfer while rx gaps are on
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      hold = rx_gaps_on ? $urandom_range(0, 10) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // entered and left at a falling edge
  task automatic send_request(logic op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_lookup_key  <= key;
    in_write_value <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.write_capacity(value);
    capacity_writes++;
  endtask

  function automatic logic [DATA_W-1:0] extreme_key();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin
    logic [CAP_W-1:0]  cap_plan [10];
    logic [DATA_W-1:0] key_pool [24];
    logic [DATA_W-1:0] base_key;
    logic [DATA_W-1:0] key;
    int                pool_size;

    cap_plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd7, 5'd1, 5'd12, 5'd3};
    capacity_writes = 0;
    tx_gaps_on      = 1'b1;
    rx_gaps_on      = 1'b1;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_op           = OP_GET;
    in_lookup_key   = '0;
    in_write_value  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty cache, extreme keys and values, update in place
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h8000_0000, 32'h1234_5678);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h8000_0001, 32'h0000_0000);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    // capacity dropped below the entries held: later put misses replace
    drain();
    write_capacity(5'd2);
    send_request(OP_PUT, 32'h0000_0001, 32'h0000_0001);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0002, 32'h0000_0002);
    // zero capacity acts as one
    drain();
    write_capacity(5'd0);
    send_request(OP_PUT, 32'h0000_0003, 32'h0000_0003);
    send_request(OP_PUT, 32'h0000_0004, 32'h0000_0004);
    send_request(OP_GET, 32'h0000_0003, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0004, 32'h0000_0000);
    drain();
    write_capacity(5'd31);
    send_request(OP_PUT, 32'h0000_0005, 32'hDEAD_BEEF);
    send_request(OP_GET, 32'h0000_0005, 32'h0000_0000);

    foreach (cap_plan[p]) begin
      drain();
      write_capacity(cap_plan[p]);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      // working set a little larger than the capacity, so hits and evictions mix
      pool_size = board.capped_capacity() + $urandom_range(1, 6);
      base_key  = $urandom;
      for (int i = 0; i < pool_size; i++) begin
        case ($urandom_range(0, 3))
          0:       key_pool[i] = base_key ^ (32'h1 << $urandom_range(0, 31));
          1:       key_pool[i] = extreme_key();
          default: key_pool[i] = $urandom;
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, pool_size - 1)];
        send_request(1'($urandom_range(0, 1)), key, $urandom);
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    $display("covered %0d requests over %0d capacity settings", board.requests,
             capacity_writes + 1);
    $display("%0d hits, %0d evictions, %0d mismatches", board.hits, board.evictions,
             board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS lru_key_value_cache_top");
    end else begin
      $display("FAIL lru_key_value_cache_top");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL lru_key_value_cache_top");
    $finish;
  end

endmodule
